// ===== rtl/field_decode_scale_clamp_assert.svh =====
// Assertion macros shared by the field decode, scale and clamp block.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef FIELD_DECODE_SCALE_CLAMP_ASSERT_SVH
`define FIELD_DECODE_SCALE_CLAMP_ASSERT_SVH
`ifndef SYNTH
`define FDSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FDSC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define FDSC_ASSERT(label, prop, msg)
`define FDSC_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== rtl/fdsc_pkg.sv =====
// Types and constants for the field decode, scale and clamp block.
// No dependencies; the modules and the bench refer to this package by scoped names.
package fdsc_pkg;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHIFT = 3'd1,
        ST_UOVF  = 3'd2,
        ST_BCD   = 3'd3,
        ST_DEN   = 3'd4,
        ST_SCALE = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_FIELD_MASK        = 3'd0,
        REG_FIELD_SHIFT       = 3'd1,
        REG_VALUE_ENCODING    = 3'd2,
        REG_SCALE_NUMERATOR   = 3'd3,
        REG_SCALE_DENOMINATOR = 3'd4,
        REG_CLAMP_LOW         = 3'd5,
        REG_CLAMP_HIGH        = 3'd6,
        REG_CLAMP_ENABLES     = 3'd7
    } reg_index_t;

    localparam logic [1:0] ENC_SIGNED = 2'd1;
    localparam logic [1:0] ENC_BCD    = 2'd2;

    localparam logic [63:0] INT_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POW10_4  = 64'd10000;
    localparam logic [63:0] POW10_8  = 64'd100000000;
    localparam logic [63:0] POW10_12 = 64'd1000000000000;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_BITS = 2;
    localparam int unsigned DIV_STAGES = 64;

    typedef struct packed {
        logic [63:0] raw_word;
        logic [6:0]  source_width;
    } item_t;

    typedef struct packed {
        logic signed [63:0] decoded_value;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic [63:0] field_mask;
        logic [6:0]  field_shift;
        logic [1:0]  value_encoding;
        logic [63:0] scale_numerator;
        logic [63:0] scale_denominator;
        logic [63:0] clamp_low;
        logic [63:0] clamp_high;
        logic [1:0]  clamp_enables;
    } cfg_t;

    // Decoded field on its way from the front end to the scaler.
    typedef struct packed {
        logic [63:0] value;
        status_t     status;
    } dec_item_t;

    // Product magnitude and quotient sign on their way to the divider.
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
        status_t     status;
    } div_item_t;

endpackage

// ===== rtl/fdsc_queue.sv =====
// Four-entry transaction queue between the decode front end and the scaler.
// Depends on fdsc_pkg and the assertion macro header.
`include "field_decode_scale_clamp_assert.svh"

module fdsc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fdsc_pkg::dec_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output fdsc_pkg::dec_item_t out_item
);

    localparam int unsigned PB = fdsc_pkg::QUEUE_PTR_BITS;

    fdsc_pkg::dec_item_t mem [0:fdsc_pkg::QUEUE_DEPTH-1];
    logic [PB-1:0] wr_ptr_reg;
    logic [PB-1:0] rd_ptr_reg;
    logic [PB:0]   count_reg;
    logic [PB:0]   count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != (PB+1)'(fdsc_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    `FDSC_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not follow a push")
    `FDSC_ASSERT_NEXT(a_head_holds, out_valid && !out_ready, out_valid && (out_item == $past(out_item)), "queue head changed while stalled")

endmodule

// ===== rtl/fdsc_front.sv =====
// Front end: masks and shifts the raw word, then decodes it as unsigned,
// signed or packed BCD in two pipeline stages. Depends on fdsc_pkg.
module fdsc_front #(
    parameter int unsigned WORD_BITS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fdsc_pkg::item_t     item,
    input  fdsc_pkg::cfg_t      cfg,
    output logic                dec_valid,
    input  logic                dec_ready,
    output fdsc_pkg::dec_item_t dec
);

    localparam logic [6:0] WIDTH_MAX = 7'(WORD_BITS);

    logic [6:0]  width_eff;
    logic [63:0] width_mask;
    logic [63:0] scoped;
    logic [63:0] filtered;
    logic [63:0] shifted_mask;
    logic [63:0] smear;
    logic [63:0] top_bit;
    logic        field_sign;
    logic        bcd_bad;
    logic [14:0] group_sum [0:3];

    logic        a_valid_reg;
    logic [63:0] a_unsigned_reg;
    logic [63:0] a_signed_reg;
    logic [14:0] a_group_reg [0:3];
    logic        a_bcd_bad_reg;
    logic [1:0]  a_enc_reg;
    logic        a_shift_bad_reg;

    logic                b_valid_reg;
    fdsc_pkg::dec_item_t b_item_reg;
    fdsc_pkg::dec_item_t b_item_next;
    logic [63:0]         bcd_value;
    logic                adv_a;
    logic                adv_b;

    assign adv_b      = !b_valid_reg || dec_ready;
    assign adv_a      = !a_valid_reg || adv_b;
    assign item_ready = adv_a;
    assign dec_valid  = b_valid_reg;
    assign dec        = b_item_reg;

    always_comb
    begin
        width_eff = item.source_width;
        if (width_eff == 7'd0 || width_eff > WIDTH_MAX)
        begin
            width_eff = WIDTH_MAX;
        end
        width_mask   = {64{1'b1}} >> (7'd64 - width_eff);
        scoped       = cfg.field_mask & width_mask;
        filtered     = (item.raw_word & scoped) >> cfg.field_shift[5:0];
        shifted_mask = scoped >> cfg.field_shift[5:0];
        // Smear the mask down so that it covers every bit below its top bit.
        smear = shifted_mask;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        smear = smear | (smear >> 32);
        top_bit    = smear & ~(smear >> 1);
        field_sign = |(filtered & top_bit);
        // Nibbles above the field are zero, so every nibble can be checked.
        bcd_bad = 1'b0;
        for (int j = 0; j < 16; j++)
        begin
            if (filtered[4*j +: 4] > 4'd9)
            begin
                bcd_bad = 1'b1;
            end
        end
        for (int g = 0; g < 4; g++)
        begin
            group_sum[g] = 15'(filtered[16*g +: 4])
                         + 15'(filtered[16*g+4 +: 4]) * 15'd10
                         + 15'(filtered[16*g+8 +: 4]) * 15'd100
                         + 15'(filtered[16*g+12 +: 4]) * 15'd1000;
        end
    end

    always_comb
    begin
        bcd_value = 64'(a_group_reg[3]) * fdsc_pkg::POW10_12
                  + 64'(a_group_reg[2]) * fdsc_pkg::POW10_8
                  + 64'(a_group_reg[1]) * fdsc_pkg::POW10_4
                  + 64'(a_group_reg[0]);
        b_item_next.value  = a_unsigned_reg;
        b_item_next.status = fdsc_pkg::ST_OK;
        if (a_shift_bad_reg)
        begin
            b_item_next.status = fdsc_pkg::ST_SHIFT;
        end
        else
        begin
            unique case (a_enc_reg)
                fdsc_pkg::ENC_SIGNED:
                begin
                    b_item_next.value = a_signed_reg;
                end
                fdsc_pkg::ENC_BCD:
                begin
                    b_item_next.value = bcd_value;
                    if (a_bcd_bad_reg)
                    begin
                        b_item_next.status = fdsc_pkg::ST_BCD;
                    end
                end
                default:
                begin
                    if (a_unsigned_reg[63])
                    begin
                        b_item_next.status = fdsc_pkg::ST_UOVF;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= item_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_unsigned_reg  <= filtered;
            a_signed_reg    <= field_sign ? (filtered | ~smear) : filtered;
            a_bcd_bad_reg   <= bcd_bad;
            a_enc_reg       <= cfg.value_encoding;
            a_shift_bad_reg <= cfg.field_shift[6];
            for (int g = 0; g < 4; g++)
            begin
                a_group_reg[g] <= group_sum[g];
            end
        end
        if (adv_b)
        begin
            b_item_reg <= b_item_next;
        end
    end

endmodule

// ===== rtl/fdsc_mul.sv =====
// Scaler multiply: 64 by 64 magnitude product from four 32 by 32 partial
// products over three stages, with range check. Depends on fdsc_pkg.
module fdsc_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  fdsc_pkg::dec_item_t in_item,
    input  fdsc_pkg::cfg_t      cfg,
    output logic                out_valid,
    output fdsc_pkg::div_item_t out_item
);

    logic [63:0] pa;
    logic [63:0] pb;

    logic          m1_valid_reg;
    logic [63:0]   m1_pp_reg [0:3];
    logic          m1_neg_reg;
    logic          m1_zero_reg;
    fdsc_pkg::status_t m1_status_reg;

    logic          m2_valid_reg;
    logic [127:0]  m2_prod_reg;
    logic          m2_neg_reg;
    logic          m2_zero_reg;
    fdsc_pkg::status_t m2_status_reg;

    logic                out_valid_reg;
    fdsc_pkg::div_item_t out_item_reg;
    fdsc_pkg::div_item_t out_item_next;

    logic [63:0] limit;
    logic        range_ovf;
    logic        pneg;
    logic        min_ovf;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign pa = in_item.value[63] ? (64'd0 - in_item.value) : in_item.value;
    assign pb = cfg.scale_numerator[63] ? (64'd0 - cfg.scale_numerator)
                                        : cfg.scale_numerator;

    always_comb
    begin
        limit     = m2_neg_reg ? fdsc_pkg::INT_MIN : fdsc_pkg::INT_MAX;
        range_ovf = !m2_zero_reg
                    && ((|m2_prod_reg[127:64]) || (m2_prod_reg[63:0] > limit));
        pneg      = m2_neg_reg && !m2_zero_reg;
        // The most negative product divided by minus one does not fit.
        min_ovf   = pneg && (m2_prod_reg[63:0] == fdsc_pkg::INT_MIN)
                    && (cfg.scale_denominator == {64{1'b1}});
        out_item_next.mag    = m2_prod_reg[63:0];
        out_item_next.neg    = pneg ^ cfg.scale_denominator[63];
        out_item_next.status = m2_status_reg;
        if (m2_status_reg == fdsc_pkg::ST_OK)
        begin
            if (cfg.scale_denominator == 64'd0)
            begin
                out_item_next.status = fdsc_pkg::ST_DEN;
            end
            else if (range_ovf || min_ovf)
            begin
                out_item_next.status = fdsc_pkg::ST_SCALE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m1_valid_reg  <= in_valid;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_pp_reg[0]  <= 64'(pa[31:0]) * 64'(pb[31:0]);
            m1_pp_reg[1]  <= 64'(pa[31:0]) * 64'(pb[63:32]);
            m1_pp_reg[2]  <= 64'(pa[63:32]) * 64'(pb[31:0]);
            m1_pp_reg[3]  <= 64'(pa[63:32]) * 64'(pb[63:32]);
            m1_neg_reg    <= in_item.value[63] ^ cfg.scale_numerator[63];
            m1_zero_reg   <= (in_item.value == 64'd0) || (cfg.scale_numerator == 64'd0);
            m1_status_reg <= in_item.status;

            m2_prod_reg   <= {m1_pp_reg[3], 64'd0}
                           + {32'd0, m1_pp_reg[2], 32'd0}
                           + {32'd0, m1_pp_reg[1], 32'd0}
                           + {64'd0, m1_pp_reg[0]};
            m2_neg_reg    <= m1_neg_reg;
            m2_zero_reg   <= m1_zero_reg;
            m2_status_reg <= m1_status_reg;

            out_item_reg  <= out_item_next;
        end
    end

endmodule

// ===== rtl/fdsc_div.sv =====
// Scaler divide and clamp: 64-stage restoring divider, one quotient bit per
// stage, then sign, clamp and the result register. Depends on fdsc_pkg and the assertion macro header.
`include "field_decode_scale_clamp_assert.svh"

module fdsc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  fdsc_pkg::div_item_t in_item,
    input  fdsc_pkg::cfg_t      cfg,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output fdsc_pkg::result_t   out_item
);

    localparam int unsigned NS = fdsc_pkg::DIV_STAGES;

    logic [63:0] divisor;

    logic [NS-1:0]     valid_reg;
    logic [63:0]       rem_reg    [0:NS-1];
    logic [63:0]       nq_reg     [0:NS-1];
    logic              neg_reg    [0:NS-1];
    fdsc_pkg::status_t status_reg [0:NS-1];

    logic [63:0]       rem_in     [0:NS-1];
    logic [63:0]       nq_in      [0:NS-1];
    logic              neg_in     [0:NS-1];
    fdsc_pkg::status_t status_in  [0:NS-1];
    logic [64:0]       partial    [0:NS-1];
    logic              qbit       [0:NS-1];
    logic [63:0]       rem_next   [0:NS-1];

    logic [63:0]       quot;
    logic [63:0]       clamped;
    logic                out_valid_reg;
    fdsc_pkg::result_t out_item_reg;
    fdsc_pkg::result_t out_item_next;

    assign advance   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign divisor   = cfg.scale_denominator[63] ? (64'd0 - cfg.scale_denominator)
                                                 : cfg.scale_denominator;

    always_comb
    begin
        rem_in[0]    = 64'd0;
        nq_in[0]     = in_item.mag;
        neg_in[0]    = in_item.neg;
        status_in[0] = in_item.status;
        for (int i = 1; i < NS; i++)
        begin
            rem_in[i]    = rem_reg[i-1];
            nq_in[i]     = nq_reg[i-1];
            neg_in[i]    = neg_reg[i-1];
            status_in[i] = status_reg[i-1];
        end
        for (int i = 0; i < NS; i++)
        begin
            partial[i] = {rem_in[i], nq_in[i][63]};
            qbit[i]    = (partial[i] >= {1'b0, divisor});
            rem_next[i] = qbit[i] ? 64'(partial[i] - {1'b0, divisor}) : partial[i][63:0];
        end
    end

    always_comb
    begin
        quot    = neg_reg[NS-1] ? (64'd0 - nq_reg[NS-1]) : nq_reg[NS-1];
        clamped = quot;
        // Lower bound first, so with crossed bounds the upper bound wins.
        if (cfg.clamp_enables[0] && ($signed(clamped) < $signed(cfg.clamp_low)))
        begin
            clamped = cfg.clamp_low;
        end
        if (cfg.clamp_enables[1] && ($signed(clamped) > $signed(cfg.clamp_high)))
        begin
            clamped = cfg.clamp_high;
        end
        out_item_next.status        = status_reg[NS-1];
        out_item_next.decoded_value = (status_reg[NS-1] == fdsc_pkg::ST_OK) ? clamped : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[NS-2:0], in_valid};
            out_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NS; i++)
            begin
                rem_reg[i]    <= rem_next[i];
                nq_reg[i]     <= {nq_in[i][62:0], qbit[i]};
                neg_reg[i]    <= neg_in[i];
                status_reg[i] <= status_in[i];
            end
            out_item_reg <= out_item_next;
        end
    end

    `FDSC_ASSERT(a_err_zero, (out_valid_reg && (out_item_reg.status != fdsc_pkg::ST_OK)) |-> (out_item_reg.decoded_value == 64'd0), "error result carries a nonzero value")
    `FDSC_ASSERT(a_ok_den, (out_valid_reg && (out_item_reg.status == fdsc_pkg::ST_OK)) |-> (cfg.scale_denominator != 64'd0), "good result with a zero denominator")

endmodule

// ===== rtl/field_decode_scale_clamp.sv =====
// Top level of the field decode, scale and clamp block: configuration
// registers and the front end, queue, multiplier and divider. Depends on fdsc_pkg.
//
// Takes one transaction per clock while item_ready is high and returns one
// result per transaction, in order. A transaction passes 71 register stages:
// two for field extraction and decode (the first loads at the accepting edge),
// one in the queue, three for the 64 by 64 multiply, 64 for the
// one-bit-per-stage divider and one for sign and clamp. The front end keeps
// accepting while a finished result waits, until its four-entry queue and its
// own two stages are full.
module field_decode_scale_clamp #(
    parameter int unsigned WORD_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fdsc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output fdsc_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    fdsc_pkg::cfg_t cfg_reg;

    logic                fe_valid;
    logic                fe_ready;
    fdsc_pkg::dec_item_t fe_item;
    logic                q_valid;
    fdsc_pkg::dec_item_t q_item;
    logic                mul_valid;
    fdsc_pkg::div_item_t mul_item;
    logic                advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_mask        <= {64{1'b1}};
            cfg_reg.field_shift       <= 7'd0;
            cfg_reg.value_encoding    <= 2'd0;
            cfg_reg.scale_numerator   <= 64'd1;
            cfg_reg.scale_denominator <= 64'd1;
            cfg_reg.clamp_low         <= fdsc_pkg::INT_MIN;
            cfg_reg.clamp_high        <= fdsc_pkg::INT_MAX;
            cfg_reg.clamp_enables     <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (fdsc_pkg::reg_index_t'(cfg_index))
                fdsc_pkg::REG_FIELD_MASK:        cfg_reg.field_mask        <= cfg_data;
                fdsc_pkg::REG_FIELD_SHIFT:       cfg_reg.field_shift       <= cfg_data[6:0];
                fdsc_pkg::REG_VALUE_ENCODING:    cfg_reg.value_encoding    <= cfg_data[1:0];
                fdsc_pkg::REG_SCALE_NUMERATOR:   cfg_reg.scale_numerator   <= cfg_data;
                fdsc_pkg::REG_SCALE_DENOMINATOR: cfg_reg.scale_denominator <= cfg_data;
                fdsc_pkg::REG_CLAMP_LOW:         cfg_reg.clamp_low         <= cfg_data;
                fdsc_pkg::REG_CLAMP_HIGH:        cfg_reg.clamp_high        <= cfg_data;
                fdsc_pkg::REG_CLAMP_ENABLES:     cfg_reg.clamp_enables     <= cfg_data[1:0];
                default:                         cfg_reg.clamp_enables     <= cfg_reg.clamp_enables;
            endcase
        end
    end

    fdsc_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .dec_valid  (fe_valid),
        .dec_ready  (fe_ready),
        .dec        (fe_item)
    );

    fdsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_ready (advance),
        .out_item  (q_item)
    );

    fdsc_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .cfg       (cfg_reg),
        .out_valid (mul_valid),
        .out_item  (mul_item)
    );

    fdsc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_item   (mul_item),
        .cfg       (cfg_reg),
        .advance   (advance),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_item  (result)
    );

endmodule

// ===== bench/field_decode_scale_clamp_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for field_decode_scale_clamp: a directed table, then random
// transactions under several register settings, checked against a local predictor.
// Depends on fdsc_pkg and the field_decode_scale_clamp RTL.
module field_decode_scale_clamp_tb;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 5000;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    fdsc_pkg::item_t   item;
    logic              result_valid;
    logic              result_ready;
    fdsc_pkg::result_t result;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [63:0]       cfg_data;

    field_decode_scale_clamp u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the register file.
    logic [63:0] m_mask;
    logic [6:0]  m_shift;
    logic [1:0]  m_enc;
    logic [63:0] m_num;
    logic [63:0] m_den;
    logic [63:0] m_lo;
    logic [63:0] m_hi;
    logic [1:0]  m_clen;

    fdsc_pkg::result_t pending_results[$];
    int                error_count;
    int                idle_cycles;
    bit                rx_drain;

    typedef struct {
        logic [63:0]       raw;
        logic [6:0]        width;
        bit                known;
        logic [63:0]       value;
        fdsc_pkg::status_t st;
    } stim_row_t;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] abs64(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic fdsc_pkg::result_t predict_decode(logic [63:0] raw, logic [6:0] wid);
        fdsc_pkg::result_t r;
        logic [63:0] scoped, filtered, dec, fmask, digit, limit, pa, pb, prod, q;
        int          w, fb, k;
        bit          neg;
        r.decoded_value = '0;
        if (m_shift >= 64)
        begin
            r.status = fdsc_pkg::ST_SHIFT;
            return r;
        end
        w = (wid == 0 || wid > 64) ? 64 : int'(wid);
        scoped = m_mask & ((w >= 64) ? '1 : ((64'd1 << w) - 1));
        filtered = (raw & scoped) >> m_shift;
        fmask = scoped >> m_shift;
        fb = 0;
        for (int i = 0; i < 64; i++)
            if (fmask[i]) fb = i + 1;
        if (m_enc == fdsc_pkg::ENC_SIGNED)
        begin
            if (fb == 0) dec = '0;
            else if (fb >= 64) dec = filtered;
            else
            begin
                dec = filtered & ((64'd1 << fb) - 1);
                if (dec[fb-1]) dec = dec | ~((64'd1 << fb) - 1);
            end
        end
        else if (m_enc == fdsc_pkg::ENC_BCD)
        begin
            dec = '0;
            for (k = (fb + 3) / 4 - 1; k >= 0; k--)
            begin
                digit = (filtered >> (k * 4)) & 64'hF;
                if (digit > 9)
                begin
                    r.status = fdsc_pkg::ST_BCD;
                    return r;
                end
                dec = dec * 10 + digit;
            end
        end
        else
        begin
            if (filtered[63])
            begin
                r.status = fdsc_pkg::ST_UOVF;
                return r;
            end
            dec = filtered;
        end
        if (m_den == 0)
        begin
            r.status = fdsc_pkg::ST_DEN;
            return r;
        end
        prod = '0;
        if (dec != 0 && m_num != 0)
        begin
            neg = dec[63] ^ m_num[63];
            limit = neg ? fdsc_pkg::INT_MIN : fdsc_pkg::INT_MAX;
            pa = abs64(dec);
            pb = abs64(m_num);
            if (pa > limit / pb)
            begin
                r.status = fdsc_pkg::ST_SCALE;
                return r;
            end
            prod = pa * pb;
            if (neg) prod = 64'd0 - prod;
        end
        if (prod == fdsc_pkg::INT_MIN && m_den == '1)
        begin
            r.status = fdsc_pkg::ST_SCALE;
            return r;
        end
        q = abs64(prod) / abs64(m_den);
        if (prod[63] ^ m_den[63]) q = 64'd0 - q;
        if (m_clen[0] && $signed(q) < $signed(m_lo)) q = m_lo;
        if (m_clen[1] && $signed(q) > $signed(m_hi)) q = m_hi;
        r.decoded_value = q;
        r.status = fdsc_pkg::ST_OK;
        return r;
    endfunction

    // Called only while nothing is in flight; the enable is dropped by the
    // next send or wait.
    task automatic write_reg(fdsc_pkg::reg_index_t idx, logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            fdsc_pkg::REG_FIELD_MASK:        m_mask  = data;
            fdsc_pkg::REG_FIELD_SHIFT:       m_shift = data[6:0];
            fdsc_pkg::REG_VALUE_ENCODING:    m_enc   = data[1:0];
            fdsc_pkg::REG_SCALE_NUMERATOR:   m_num   = data;
            fdsc_pkg::REG_SCALE_DENOMINATOR: m_den   = data;
            fdsc_pkg::REG_CLAMP_LOW:         m_lo    = data;
            fdsc_pkg::REG_CLAMP_HIGH:        m_hi    = data;
            default:                         m_clen  = data[1:0];
        endcase
    endtask

    task automatic wait_results_done();
        item_valid <= 1'b0;
        cfg_we     <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Offers one transaction; the expectation is queued when it is accepted.
    // Valid stays high afterwards so that the next send follows with no gap.
    task automatic send_item(logic [63:0] raw, logic [6:0] wid, bit known,
                             logic [63:0] value, fdsc_pkg::status_t st);
        fdsc_pkg::result_t r;
        r = predict_decode(raw, wid);
        if (known && (r.decoded_value !== value || r.status !== st))
            $error("table row disagrees with predictor: raw=%h width=%0d", raw, wid);
        cfg_we <= 1'b0;
        item_valid <= 1'b1;
        item.raw_word <= raw;
        item.source_width <= wid;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        pending_results.insert(pending_results.size(), r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_edge64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return fdsc_pkg::INT_MIN;
            3: return fdsc_pkg::INT_MAX;
            4: return 64'd1;
            5: return {{56{$urandom_range(0, 1) == 1}}, 8'($urandom())};
            6: return 64'($urandom_range(0, 1000));
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] rand_bcd();
        logic [63:0] v;
        for (int i = 0; i < 16; i++)
            v[i*4 +: 4] = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                       : 4'($urandom_range(0, 9));
        return v;
    endfunction

    // Result side: random back-pressure and the field-by-field compare.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $error("unexpected result transaction: value=%h status=%0d",
                           result.decoded_value, result.status);
                end
                else
                begin
                    if (result.decoded_value !== pending_results[0].decoded_value)
                    begin
                        error_count++;
                        $error("decoded_value expected %h actual %h",
                               pending_results[0].decoded_value, result.decoded_value);
                    end
                    if (result.status !== pending_results[0].status)
                    begin
                        error_count++;
                        $error("status expected %0d actual %0d",
                               pending_results[0].status, result.status);
                    end
                    void'(pending_results.pop_front());
                end
            end
            if (rx_drain)
                result_ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0)
                result_ready <= 1'b0;
            else if (!result_ready && $urandom_range(0, 3) != 0)
                result_ready <= result_ready;
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        logic [63:0] raw;
        int          phase;

        error_count  = 0;
        idle_cycles  = 0;
        rx_drain     = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = fdsc_pkg::REG_FIELD_MASK;
        cfg_data     = '0;
        m_mask = '1; m_shift = '0; m_enc = '0; m_num = 64'd1; m_den = 64'd1;
        m_lo = fdsc_pkg::INT_MIN; m_hi = fdsc_pkg::INT_MAX; m_clen = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: unsigned identity.
        rows.insert(rows.size(), '{64'd0, 7'd0, 1, 64'd0, fdsc_pkg::ST_OK});
        rows.insert(rows.size(), '{fdsc_pkg::INT_MAX, 7'd0, 1, fdsc_pkg::INT_MAX,
                                   fdsc_pkg::ST_OK});
        rows.insert(rows.size(), '{'1, 7'd0, 1, 64'd0, fdsc_pkg::ST_UOVF});
        rows.insert(rows.size(), '{'1, 7'd8, 1, 64'd255, fdsc_pkg::ST_OK});
        rows.insert(rows.size(), '{'1, 7'd127, 1, 64'd0, fdsc_pkg::ST_UOVF});
        rows.insert(rows.size(), '{'1, 7'd63, 1, fdsc_pkg::INT_MAX, fdsc_pkg::ST_OK});
        rows.insert(rows.size(), '{64'h1234, 7'd1, 1, 64'd0, fdsc_pkg::ST_OK});
        foreach (rows[i])
            send_item(rows[i].raw, rows[i].width, rows[i].known, rows[i].value, rows[i].st);
        wait_results_done();

        // Signed decode, including an empty field and sign extension.
        write_reg(fdsc_pkg::REG_VALUE_ENCODING, 64'(fdsc_pkg::ENC_SIGNED));
        write_reg(fdsc_pkg::REG_FIELD_MASK, 64'h0000_0000_0000_FF00);
        write_reg(fdsc_pkg::REG_FIELD_SHIFT, 64'd8);
        send_item(64'h0000_0000_0000_8000, 7'd16, 1, 64'hFFFF_FFFF_FFFF_FF80,
                  fdsc_pkg::ST_OK);
        send_item(64'h0000_0000_0000_7F00, 7'd16, 1, 64'd127, fdsc_pkg::ST_OK);
        send_item(64'hFFFF, 7'd8, 1, 64'd0, fdsc_pkg::ST_OK);
        wait_results_done();
        // Crossed clamp bounds, field value and denominator signs.
        write_reg(fdsc_pkg::REG_SCALE_NUMERATOR, 64'd7);
        write_reg(fdsc_pkg::REG_SCALE_DENOMINATOR, -64'sd2);
        write_reg(fdsc_pkg::REG_CLAMP_LOW, 64'd100);
        write_reg(fdsc_pkg::REG_CLAMP_HIGH, 64'd50);
        write_reg(fdsc_pkg::REG_CLAMP_ENABLES, 64'd3);
        send_item(64'h0000_0000_0000_0500, 7'd16, 1, 64'd50, fdsc_pkg::ST_OK);
        wait_results_done();
        write_reg(fdsc_pkg::REG_CLAMP_ENABLES, 64'd0);
        send_item(64'h0000_0000_0000_0500, 7'd16, 1, -64'sd17, fdsc_pkg::ST_OK);
        send_item(64'h0000_0000_0000_FB00, 7'd16, 1, 64'd17, fdsc_pkg::ST_OK);
        wait_results_done();
        write_reg(fdsc_pkg::REG_SCALE_DENOMINATOR, 64'd0);
        send_item(64'h0000_0000_0000_0500, 7'd16, 1, 64'd0, fdsc_pkg::ST_DEN);
        wait_results_done();
        // Full-width signed: minimum divided by minus one, and product overflow.
        write_reg(fdsc_pkg::REG_FIELD_MASK, '1);
        write_reg(fdsc_pkg::REG_FIELD_SHIFT, 64'd0);
        write_reg(fdsc_pkg::REG_SCALE_NUMERATOR, 64'd1);
        write_reg(fdsc_pkg::REG_SCALE_DENOMINATOR, '1);
        send_item(fdsc_pkg::INT_MIN, 7'd0, 1, 64'd0, fdsc_pkg::ST_SCALE);
        send_item(64'd5, 7'd0, 1, -64'sd5, fdsc_pkg::ST_OK);
        wait_results_done();
        write_reg(fdsc_pkg::REG_SCALE_NUMERATOR, 64'd2);
        send_item(fdsc_pkg::INT_MAX, 7'd0, 1, 64'd0, fdsc_pkg::ST_SCALE);
        send_item(64'hC000_0000_0000_0000, 7'd0, 0, 64'd0, fdsc_pkg::ST_OK);
        wait_results_done();
        // BCD with a bad digit, unused encoding and a bad shift.
        write_reg(fdsc_pkg::REG_SCALE_NUMERATOR, 64'd1);
        write_reg(fdsc_pkg::REG_SCALE_DENOMINATOR, 64'd1);
        write_reg(fdsc_pkg::REG_VALUE_ENCODING, 64'(fdsc_pkg::ENC_BCD));
        send_item(64'h9876, 7'd16, 1, 64'd9876, fdsc_pkg::ST_OK);
        send_item(64'h98A6, 7'd16, 1, 64'd0, fdsc_pkg::ST_BCD);
        send_item(64'h9999_9999_9999_9999, 7'd0, 1, 64'd9999999999999999,
                  fdsc_pkg::ST_OK);
        wait_results_done();
        write_reg(fdsc_pkg::REG_VALUE_ENCODING, 64'd3);
        send_item(64'h98A6, 7'd16, 1, 64'h98A6, fdsc_pkg::ST_OK);
        wait_results_done();
        write_reg(fdsc_pkg::REG_FIELD_SHIFT, 64'd64);
        send_item(64'h98A6, 7'd16, 1, 64'd0, fdsc_pkg::ST_SHIFT);
        wait_results_done();

        // Random phases, each with a fresh register setting.
        for (phase = 0; phase < 16; phase++)
        begin
            write_reg(fdsc_pkg::REG_FIELD_MASK,
                      ($urandom_range(0, 2) == 0) ? '1 : rand_edge64());
            write_reg(fdsc_pkg::REG_FIELD_SHIFT, ($urandom_range(0, 9) == 0)
                ? 64'($urandom_range(64, 127)) : 64'($urandom_range(0, 63)));
            write_reg(fdsc_pkg::REG_VALUE_ENCODING, 64'($urandom_range(0, 3)));
            write_reg(fdsc_pkg::REG_SCALE_NUMERATOR, rand_edge64());
            write_reg(fdsc_pkg::REG_SCALE_DENOMINATOR, (phase == 3) ? 64'd0 : rand_edge64());
            write_reg(fdsc_pkg::REG_CLAMP_LOW, rand_edge64());
            write_reg(fdsc_pkg::REG_CLAMP_HIGH, rand_edge64());
            write_reg(fdsc_pkg::REG_CLAMP_ENABLES, 64'($urandom_range(0, 3)));
            if (phase == 0)
            begin
                write_reg(fdsc_pkg::REG_FIELD_MASK, '1);
                write_reg(fdsc_pkg::REG_FIELD_SHIFT, 64'd0);
            end
            for (int n = 0; n < 50; n++)
            begin
                raw = (m_enc == fdsc_pkg::ENC_BCD && $urandom_range(0, 3) != 0)
                    ? rand_bcd() : rand_edge64();
                if ($urandom_range(0, 1) == 0) raw = rand64();
                send_item(raw, 7'($urandom_range(0, 127)), 0, 64'd0, fdsc_pkg::ST_OK);
                if (phase != 5) pause_random();
                // Hold the sender until every expected result has come back.
                if (n == 25 && phase[0]) wait_results_done();
            end
            if (phase == 8) rx_drain = 1'b1;
            if (phase == 12) rx_drain = 1'b0;
            wait_results_done();
        end

        rx_drain = 1'b1;
        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
